// ===== rtl/stmi_pkg.sv =====
package stmi_pkg;

   // defaults for the top-level parameters
   localparam int SERVO_COUNT_DEF = 6;
   localparam int FRAC_BITS_DEF   = 8;

   // fixed field widths
   localparam int IDX_IN_W = 3;
   localparam int AIM_W    = 12;
   localparam int SP_W     = 10;
   localparam int TIME_W   = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // register reset values
   localparam logic [AIM_W-1:0]  AIM_MIN_RESET     = 12'd510;
   localparam logic [AIM_W-1:0]  AIM_MAX_RESET     = 12'd2490;
   localparam logic [SP_W-1:0]   STEP_PERIOD_RESET = 10'd20;
   localparam logic [TIME_W-1:0] MAX_TIME_RESET    = 16'd10000;

   // per-servo state reset (integer microseconds)
   localparam logic [AIM_W-1:0]  SERVO_RESET_US = 12'd1500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AIM_MIN     = 2'd0,
      CSR_AIM_MAX     = 2'd1,
      CSR_STEP_PERIOD = 2'd2,
      CSR_MAX_TIME    = 2'd3
   } csr_reg_type;

   localparam logic CMD_SET  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // divider control/status between sequencer and divider
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== rtl/stmi_divider.sv =====
module stmi_divider
   import stmi_pkg::*;
#(
   parameter int DIVIDEND_W = 31,
   parameter int DIVISOR_W  = TIME_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  div_ctrl_type          ctrl,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output div_stat_type          stat,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   // restoring divider, one quotient bit per cycle, MSB first
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial   = {1'b0, shifted} - {2'b00, div_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIVISOR_W+1]) begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// ===== rtl/servo_timed_move_interpolator.sv =====
// Channel  Dir  Bits          Contents (lowest bit up)
// req      in   tdata[31:0]   servo_index[2:0], target_us[14:3], move_time_ms[30:15]
//               tuser[0]      command (0 set, 1 tick)
// rsp      out  tdata[15:0]   position_us[11:0], moving[12]
//               tuser[0]      accepted
// csr      in   we/index/data aim_min, aim_max, step_period, max_time
//
// One item at a time. A tick with a nonzero step passes through LOAD, DECIDE, TICK,
// TDEC and WRITE after accept. A set with a real move passes through LOAD, DECIDE,
// MUL, DGO, DIV and WRITE, and waits in DIV for the restoring divider, which
// yields one quotient bit per cycle.
// Stop, short-time, zero-step tick and out-of-range items pass through LOAD,
// DECIDE and WRITE.
// Reset (synchronous) restores the configuration registers, the state and result-valid
// flags, and every servo to 1500.0 at once. A result waiting on rsp_tready does not
// block the next accept; only the write-back of the following item waits for the result register to free up.
module servo_timed_move_interpolator
   import stmi_pkg::*;
#(
   parameter int SERVO_COUNT = SERVO_COUNT_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request items
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // servo_index, target_us, move_time_ms
   input  logic                 req_tuser,   // command
   // result items
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // position_us, moving
   output logic                 rsp_tuser,   // accepted
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int IDX_W  = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
   localparam int POS_W  = AIM_W + FRAC_BITS;      // unsigned position
   localparam int STEP_W = AIM_W + 1 + FRAC_BITS;  // signed step
   localparam int PROD_W = POS_W + 1 + SP_W;       // |diff| * step_period
   localparam logic [POS_W-1:0] POS_RESET = POS_W'(SERVO_RESET_US) << FRAC_BITS;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_LOAD   = 9'b000000010,
      S_DECIDE = 9'b000000100,
      S_MUL    = 9'b000001000,
      S_DGO    = 9'b000010000,
      S_DIV    = 9'b000100000,
      S_TICK   = 9'b001000000,
      S_TDEC   = 9'b010000000,
      S_WRITE  = 9'b100000000
   } state_type;

   function automatic logic [AIM_W-1:0] clamp_aim(input logic [AIM_W-1:0] t,
                                                  input logic [AIM_W-1:0] lo,
                                                  input logic [AIM_W-1:0] hi);
      logic [AIM_W-1:0] r;
      priority if (t > hi) r = hi;
      else if (t < lo)     r = lo;
      else                 r = t;
      return r;
   endfunction

   // ---------------- configuration registers ----------------
   logic [AIM_W-1:0]  aim_min_ff, aim_max_ff;
   logic [SP_W-1:0]   step_period_ff;
   logic [TIME_W-1:0] max_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         aim_min_ff     <= AIM_MIN_RESET;
         aim_max_ff     <= AIM_MAX_RESET;
         step_period_ff <= STEP_PERIOD_RESET;
         max_time_ff    <= MAX_TIME_RESET;
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            CSR_AIM_MIN:     aim_min_ff     <= csr_wdata[AIM_W-1:0];
            CSR_AIM_MAX:     aim_max_ff     <= csr_wdata[AIM_W-1:0];
            CSR_STEP_PERIOD: step_period_ff <= csr_wdata[SP_W-1:0];
            CSR_MAX_TIME:    max_time_ff    <= csr_wdata[TIME_W-1:0];
         endcase
      end
   end

   // ---------------- per-servo state ----------------
   logic [POS_W-1:0]         pos_mem_ff  [SERVO_COUNT];
   logic [AIM_W-1:0]         tgt_mem_ff  [SERVO_COUNT];
   logic signed [STEP_W-1:0] step_mem_ff [SERVO_COUNT];

   // ---------------- sequencer registers ----------------
   state_type                state_ff;
   logic                     cmd_ff;
   logic [IDX_IN_W-1:0]      idx_ff;
   logic                     inrange_ff;
   logic [AIM_W-1:0]         aim_ff, aimc_ff, goal_ff;
   logic [TIME_W-1:0]        tm_ff, tms_ff;
   logic [POS_W-1:0]         pos_ff;            // working copy, written back
   logic [AIM_W-1:0]         tgt_ff;
   logic signed [STEP_W-1:0] step_ff;
   logic                     neg_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [POS_W:0]           dist_ff;
   logic [STEP_W:0]          two_ff;
   logic signed [STEP_W:0]   sum_ff;

   logic                     rsp_valid_ff, rsp_acc_ff, rsp_mov_ff;
   logic [AIM_W-1:0]         rsp_pos_ff;

   logic [IDX_W-1:0]         sel;
   logic                     req_fire, wr_fire;
   logic signed [POS_W:0]    set_diff, tick_diff;
   logic [POS_W:0]           set_mag;
   logic signed [STEP_W:0]   step_x2;
   logic [PROD_W-1:0]        quotient;
   logic signed [STEP_W-1:0] quo_step;
   div_ctrl_type             div_ctrl;
   div_stat_type             div_stat;

   assign sel        = idx_ff[IDX_W-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   // result register must be free (or emptying) before a new result lands
   assign wr_fire    = (state_ff == S_WRITE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      set_diff  = signed'({1'b0, aimc_ff, {FRAC_BITS{1'b0}}}) - signed'({1'b0, pos_ff});
      set_mag   = set_diff[POS_W] ? POS_W'(0) - set_diff : set_diff;
      tick_diff = signed'({1'b0, goal_ff, {FRAC_BITS{1'b0}}}) - signed'({1'b0, pos_ff});
      step_x2   = {step_ff, 1'b0};
      quo_step  = signed'(quotient[STEP_W-1:0]);
   end

   assign div_ctrl.start = (state_ff == S_DGO);

   stmi_divider #(
      .DIVIDEND_W (PROD_W),
      .DIVISOR_W  (TIME_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (prod_ff),
      .divisor  (tms_ff),
      .stat     (div_stat),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) state_ff <= S_LOAD;
            end
            S_LOAD:   state_ff <= S_DECIDE;
            S_DECIDE: begin
               priority if (!inrange_ff)
                  state_ff <= S_WRITE;
               else if (cmd_ff == CMD_SET) begin
                  if (aim_ff == '0 || tms_ff == '0 || tms_ff < TIME_W'(step_period_ff))
                     state_ff <= S_WRITE;
                  else
                     state_ff <= S_MUL;
               end else if (step_ff == '0)
                  state_ff <= S_WRITE;
               else
                  state_ff <= S_TICK;
            end
            S_MUL:  state_ff <= S_DGO;
            S_DGO:  state_ff <= S_DIV;
            S_DIV: begin
               if (div_stat.done) state_ff <= S_WRITE;
            end
            S_TICK: state_ff <= S_TDEC;
            S_TDEC: state_ff <= S_WRITE;
            S_WRITE: begin
               if (wr_fire) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath of the sequencer
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff     <= req_tuser;
         idx_ff     <= req_tdata[IDX_IN_W-1:0];
         aim_ff     <= req_tdata[IDX_IN_W +: AIM_W];
         tm_ff      <= req_tdata[IDX_IN_W+AIM_W +: TIME_W];
         inrange_ff <= ({1'b0, req_tdata[IDX_IN_W-1:0]} < (IDX_IN_W+1)'(SERVO_COUNT));
      end
      if (state_ff == S_LOAD) begin
         aimc_ff <= clamp_aim(aim_ff, aim_min_ff, aim_max_ff);
         tms_ff  <= (tm_ff > max_time_ff) ? max_time_ff : tm_ff;
         if (inrange_ff) begin
            pos_ff  <= pos_mem_ff[sel];
            tgt_ff  <= tgt_mem_ff[sel];
            step_ff <= step_mem_ff[sel];
            goal_ff <= clamp_aim(tgt_mem_ff[sel], aim_min_ff, aim_max_ff);
         end else begin
            pos_ff  <= '0;
            tgt_ff  <= '0;
            step_ff <= '0;
            goal_ff <= '0;
         end
      end
      if (state_ff == S_DECIDE && inrange_ff && cmd_ff == CMD_SET) begin
         if (aim_ff == '0) begin
            // stop and hold where it is
            tgt_ff  <= pos_ff[POS_W-1:FRAC_BITS];
            step_ff <= '0;
         end else begin
            tgt_ff  <= aimc_ff;
            step_ff <= '0;   // replaced by the quotient on a real move
         end
      end
      if (state_ff == S_MUL) begin
         neg_ff  <= set_diff[POS_W];
         prod_ff <= PROD_W'(set_mag) * PROD_W'(step_period_ff);
      end
      if (state_ff == S_DIV && div_stat.done) begin
         // quotient never exceeds |diff|, so it fits the step width
         step_ff <= neg_ff ? -quo_step : quo_step;
      end
      if (state_ff == S_TICK) begin
         dist_ff <= tick_diff[POS_W] ? POS_W'(0) - tick_diff : tick_diff;
         two_ff  <= step_x2[STEP_W] ? (STEP_W+1)'(0) - step_x2 : step_x2;
         sum_ff  <= signed'({2'b00, pos_ff}) + signed'({step_ff[STEP_W-1], step_ff});
      end
      if (state_ff == S_TDEC) begin
         if ({1'b0, dist_ff} <= two_ff) begin
            // close enough: snap to the goal and stop
            pos_ff  <= {goal_ff, {FRAC_BITS{1'b0}}};
            step_ff <= '0;
         end else begin
            priority if (sum_ff[STEP_W])
               pos_ff <= '0;
            else if (sum_ff > signed'({2'b00, {POS_W{1'b1}}}))
               pos_ff <= {POS_W{1'b1}};
            else
               pos_ff <= sum_ff[POS_W-1:0];
         end
      end
   end

   // write-back of the working copy
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SERVO_COUNT; i++) begin
            pos_mem_ff[i]  <= POS_RESET;
            tgt_mem_ff[i]  <= SERVO_RESET_US;
            step_mem_ff[i] <= '0;
         end
      end else if (wr_fire && inrange_ff) begin
         pos_mem_ff[sel]  <= pos_ff;
         tgt_mem_ff[sel]  <= tgt_ff;
         step_mem_ff[sel] <= step_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (wr_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (wr_fire) begin
         rsp_acc_ff <= inrange_ff;
         rsp_pos_ff <= inrange_ff ? pos_ff[POS_W-1:FRAC_BITS] : '0;
         rsp_mov_ff <= inrange_ff && (step_ff != '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_acc_ff;
   assign rsp_tdata  = {3'b000, rsp_mov_ff, rsp_pos_ff};

`ifndef NO_ASSERTIONS
   // the divider only runs or reports completion while the sequencer waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      (div_stat.busy || div_stat.done) |-> (state_ff == S_DIV))
      else $error("divider active outside wait state");

   // an accepted item always goes to the state read next
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_LOAD))
      else $error("accepted item not loaded");

   // a rejected servo index yields an all-zero result
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("rejected item with nonzero result");

   // a snap always stops the servo
   a_snap_stops: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_TDEC) && ({1'b0, dist_ff} <= two_ff)) |=> (step_ff == '0))
      else $error("snap left a nonzero step");
`endif

endmodule

// ===== tb/servo_timed_move_interpolator_tb.sv =====
module servo_timed_move_interpolator_tb
   import stmi_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SERVOS    = SERVO_COUNT_DEF;
   localparam int FRAC      = FRAC_BITS_DEF;
   localparam int POS_W     = AIM_W + FRAC;      // 12.8 unsigned position
   localparam int STEP_W    = POS_W + 1;         // 13.8 signed step
   localparam longint POS_TOP = (longint'(1) << POS_W) - 1;

   // Fields of one result item, as the block should report it.
   typedef struct packed {
      logic             accepted;
      logic [AIM_W-1:0] position_us;
      logic             moving;
   } ramp_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [31:0]          req_tdata;   // servo_index, target_us, move_time_ms
   logic                 req_tuser;   // command
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [15:0]          rsp_tdata;   // position_us, moving
   logic                 rsp_tuser;   // accepted
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   servo_timed_move_interpolator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Local copy of the registers.
   logic [AIM_W-1:0]  lim_lo;
   logic [AIM_W-1:0]  lim_hi;
   logic [SP_W-1:0]   tick_ms;
   logic [TIME_W-1:0] time_cap;

   // Local copy of the per-servo ramp state.
   logic [POS_W-1:0]         pos_fix  [SERVOS];
   logic [AIM_W-1:0]         goal_us  [SERVOS];
   logic signed [STEP_W-1:0] step_fix [SERVOS];

   ramp_result_type due_results[$];   // predicted, not yet seen on rsp
   int errors;
   int send_idle_pct;              // chance per cycle that the sender pauses
   int rsp_idle_pct;               // chance per cycle that rsp_tready drops
   int hold_left;                  // cycles of forced rsp back-pressure left

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on run length; far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Target clamp: the upper bound wins first, as in the block.
   function automatic logic [AIM_W-1:0] aim_clamp(input logic [AIM_W-1:0] t);
      if (t > lim_hi)
         return lim_hi;
      if (t < lim_lo)
         return lim_lo;
      return t;
   endfunction

   function automatic longint mag(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Applies one request item to the local ramp state and queues the result
   // it must produce.
   task automatic ramp_predict(input logic cmd, input logic [IDX_IN_W-1:0] idx,
                               input logic [AIM_W-1:0] aim,
                               input logic [TIME_W-1:0] tm);
      ramp_result_type r;
      logic [AIM_W-1:0] a;
      logic [TIME_W-1:0] t;
      longint diff, s, goal, cur, st, p;
      if (idx >= SERVOS) begin
         // out-of-range servo: nothing changes, all-zero result
         r = '0;
         due_results.push_back(r);
         return;
      end
      if (cmd == CMD_SET) begin
         if (aim == '0) begin
            // stop: hold where the servo is now
            step_fix[idx] = '0;
            goal_us[idx]  = pos_fix[idx][POS_W-1:FRAC];
         end else begin
            a = aim_clamp(aim);
            t = (tm > time_cap) ? time_cap : tm;
            goal_us[idx] = a;
            if (t == '0 || t < tick_ms) begin
               step_fix[idx] = '0;
            end else begin
               diff = (longint'(a) << FRAC) - longint'(pos_fix[idx]);
               s = diff * longint'(tick_ms) / longint'(t);   // truncates to zero
               step_fix[idx] = STEP_W'(s);
            end
         end
      end else if (step_fix[idx] != 0) begin
         goal = longint'(aim_clamp(goal_us[idx])) << FRAC;
         cur  = longint'(pos_fix[idx]);
         st   = longint'(step_fix[idx]);
         if (mag(goal - cur) <= mag(st * 2)) begin
            // within two steps: snap and stop
            pos_fix[idx]  = POS_W'(goal);
            step_fix[idx] = '0;
         end else begin
            p = cur + st;
            if (p < 0)
               p = 0;
            if (p > POS_TOP)
               p = POS_TOP;
            pos_fix[idx] = POS_W'(p);
         end
      end
      r.accepted    = 1'b1;
      r.position_us = pos_fix[idx][POS_W-1:FRAC];
      r.moving      = (step_fix[idx] != 0);
      due_results.push_back(r);
   endtask

   // Sends one request item. Entered and left at a falling edge; valid is
   // left high so back-to-back items never toggle it within one step.
   task automatic send_item(input logic cmd, input logic [IDX_IN_W-1:0] idx,
                            input logic [AIM_W-1:0] aim,
                            input logic [TIME_W-1:0] tm);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, tm, aim, idx};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      ramp_predict(cmd, idx, aim, tm);
      @(negedge clock);
   endtask

   // Stops sending, waits for every predicted result, then lets the block
   // run dry.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (due_results.size() != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // One register write; only called while the block is idle.
   task automatic csr_write(input csr_reg_type r, input logic [CSR_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= r;
      csr_wdata <= v;
      unique case (r)
         CSR_AIM_MIN:     lim_lo   = v[AIM_W-1:0];
         CSR_AIM_MAX:     lim_hi   = v[AIM_W-1:0];
         CSR_STEP_PERIOD: tick_ms  = v[SP_W-1:0];
         CSR_MAX_TIME:    time_cap = v[TIME_W-1:0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_config(input logic [AIM_W-1:0] lo, input logic [AIM_W-1:0] hi,
                              input logic [SP_W-1:0] sp, input logic [TIME_W-1:0] mt);
      settle();
      csr_write(CSR_AIM_MIN, CSR_W'(lo));
      csr_write(CSR_AIM_MAX, CSR_W'(hi));
      csr_write(CSR_STEP_PERIOD, CSR_W'(sp));
      csr_write(CSR_MAX_TIME, mt);
   endtask

   // ---------------- directed tests ----------------

   // Right after reset every servo sits still at 1500.
   task automatic test_reset_state();
      send_item(CMD_TICK, 3'd0, 12'd0, 16'd0);
      send_item(CMD_TICK, 3'd5, 12'd0, 16'd0);
   endtask

   // Servo indexes past the last servo are refused with an all-zero result.
   task automatic test_out_of_range();
      send_item(CMD_SET,  3'd6, 12'd4095, 16'd65535);
      send_item(CMD_TICK, 3'd7, 12'd0, 16'd0);
      send_item(CMD_SET,  3'd7, 12'd0, 16'd0);
   endtask

   // Target above aim_max and time above max_time both clamp; then a target
   // below aim_min with zero time clears the step.
   task automatic test_clamps();
      send_item(CMD_SET,  3'd1, 12'd4095, 16'd65535);
      send_item(CMD_TICK, 3'd1, 12'd0, 16'd0);
      send_item(CMD_SET,  3'd1, 12'd1, 16'd0);
      send_item(CMD_TICK, 3'd1, 12'd0, 16'd0);
   endtask

   // Time just below step_period gives no move; exactly step_period snaps in
   // one tick.
   task automatic test_short_time();
      send_item(CMD_SET,  3'd2, 12'd2000, 16'd19);
      send_item(CMD_TICK, 3'd2, 12'd0, 16'd0);
      send_item(CMD_SET,  3'd2, 12'd2000, 16'd20);
      send_item(CMD_TICK, 3'd2, 12'd0, 16'd0);
   endtask

   // Zero target mid-move: target becomes the current position.
   task automatic test_stop();
      send_item(CMD_SET,  3'd0, 12'd2400, 16'd100);
      send_item(CMD_TICK, 3'd0, 12'd0, 16'd0);
      send_item(CMD_SET,  3'd0, 12'd0, 16'd500);
      send_item(CMD_TICK, 3'd0, 12'd0, 16'd0);
   endtask

   // Target equal to position holds; a downward move snaps on |distance|.
   task automatic test_hold_and_down();
      send_item(CMD_SET,  3'd5, 12'd1500, 16'd200);
      send_item(CMD_SET,  3'd4, 12'd600, 16'd60);
      repeat (3) send_item(CMD_TICK, 3'd4, 12'd0, 16'd0);
   endtask

   // Moves the goal away from the step direction by narrowing the aim range,
   // so the position runs into its top and bottom limits.
   task automatic test_position_limits();
      load_config(12'd0, 12'd4095, 10'd20, 16'd10000);
      send_item(CMD_SET,  3'd3, 12'd4000, 16'd20);
      send_item(CMD_TICK, 3'd3, 12'd0, 16'd0);
      send_item(CMD_SET,  3'd3, 12'd4095, 16'd20);
      send_item(CMD_SET,  3'd4, 12'd95, 16'd20);
      send_item(CMD_TICK, 3'd4, 12'd0, 16'd0);
      send_item(CMD_SET,  3'd4, 12'd1, 16'd20);
      settle();
      csr_write(CSR_AIM_MAX, 16'd0);
      repeat (3) send_item(CMD_TICK, 3'd3, 12'd0, 16'd0);
      settle();
      csr_write(CSR_AIM_MIN, 16'd4095);
      csr_write(CSR_AIM_MAX, 16'd4095);
      repeat (3) send_item(CMD_TICK, 3'd4, 12'd0, 16'd0);
   endtask

   // ---------------- random tests ----------------

   // Mostly well-formed moves: sets with times a few ticks long followed by
   // ticks; some stops, short or huge times and bad indexes as noise.
   task automatic run_random_moves(input int count);
      logic cmd;
      logic [IDX_IN_W-1:0] idx;
      logic [AIM_W-1:0] aim;
      logic [TIME_W-1:0] tm;
      int r;
      for (int n = 0; n < count; n++) begin
         r   = $urandom_range(99);
         idx = ($urandom_range(99) < 5) ? IDX_IN_W'($urandom_range(7))
                                        : IDX_IN_W'($urandom_range(SERVOS - 1));
         cmd = (r < 58) ? CMD_TICK : CMD_SET;
         aim = ($urandom_range(99) < 8) ? '0 : AIM_W'($urandom_range(4095));
         r   = $urandom_range(99);
         if (r < 70)
            tm = TIME_W'(int'(tick_ms) * $urandom_range(1, 6));
         else if (r < 85)
            tm = TIME_W'($urandom_range(65535));
         else
            tm = TIME_W'($urandom_range(tick_ms));
         if (cmd == CMD_TICK && $urandom_range(1) == 1) begin
            // unused fields of a tick still carry random bits
            aim = AIM_W'($urandom_range(4095));
            tm  = TIME_W'($urandom_range(65535));
         end
         send_item(cmd, idx, aim, tm);
      end
   endtask

   // Receiver holds off for a long stretch while items keep coming, so the
   // block fills and drops req_tready.
   task automatic test_backpressure();
      settle();
      hold_left = 300;
      for (int n = 0; n < 12; n++) begin
         send_item(CMD_SET, IDX_IN_W'(n % SERVOS), AIM_W'($urandom_range(1, 4095)),
                   TIME_W'(int'(tick_ms) * 3));
         send_item(CMD_TICK, IDX_IN_W'(n % SERVOS), '0, '0);
      end
   endtask

   // Receiver side: random ready with an optional forced hold-off.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Result checker: every accepted result item against the oldest prediction.
   always @(posedge clock) begin : check_results
      ramp_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: accepted %0d pos %0d moving %0d",
                     $time, rsp_tuser, rsp_tdata[11:0], rsp_tdata[12]);
         end else begin
            want = due_results.pop_front();
            if (rsp_tuser !== want.accepted) begin
               errors++;
               $display("%0t: accepted expected %0d actual %0d",
                        $time, want.accepted, rsp_tuser);
            end
            if (rsp_tdata[11:0] !== want.position_us) begin
               errors++;
               $display("%0t: position_us expected %0d actual %0d",
                        $time, want.position_us, rsp_tdata[11:0]);
            end
            if (rsp_tdata[12] !== want.moving) begin
               errors++;
               $display("%0t: moving expected %0d actual %0d",
                        $time, want.moving, rsp_tdata[12]);
            end
         end
      end
   end

   // Main sequence
   initial begin
      errors        = 0;
      send_idle_pct = 12;
      rsp_idle_pct  = 72;
      hold_left     = 0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = CMD_SET;
      csr_we        = 1'b0;
      csr_index     = CSR_AIM_MIN;
      csr_wdata     = '0;
      lim_lo   = AIM_MIN_RESET;
      lim_hi   = AIM_MAX_RESET;
      tick_ms  = STEP_PERIOD_RESET;
      time_cap = MAX_TIME_RESET;
      for (int i = 0; i < SERVOS; i++) begin
         pos_fix[i]  = POS_W'(SERVO_RESET_US) << FRAC;
         goal_us[i]  = SERVO_RESET_US;
         step_fix[i] = '0;
      end
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_out_of_range();
      test_clamps();
      test_short_time();
      test_stop();
      test_hold_and_down();
      test_position_limits();

      // phase 1: sender mostly busy, receiver mostly stalled; reset values
      load_config(AIM_MIN_RESET, AIM_MAX_RESET, STEP_PERIOD_RESET, MAX_TIME_RESET);
      run_random_moves(150);
      test_backpressure();

      // phase 2: roles swapped; widest range, shortest tick
      settle();
      send_idle_pct = 72;
      rsp_idle_pct  = 12;
      load_config(12'd0, 12'd4095, 10'd1, 16'd65535);
      run_random_moves(150);

      // phase 3: no idling; narrow range, longest tick, time cap at tick
      settle();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      load_config(12'd1000, 12'd2000, 10'd1000, 16'd1000);
      run_random_moves(120);

      // random settings, inverted aim range possible
      load_config(AIM_W'($urandom_range(4095)), AIM_W'($urandom_range(4095)),
                  SP_W'($urandom_range(1, 1000)), TIME_W'($urandom_range(1, 65535)));
      run_random_moves(90);
      load_config(AIM_W'($urandom_range(1000)), AIM_W'($urandom_range(3000, 4095)),
                  SP_W'($urandom_range(1, 50)), TIME_W'($urandom_range(1, 65535)));
      run_random_moves(90);

      settle();
      repeat (60) @(negedge clock);
      if (due_results.size() != 0)
         errors++;
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
